>>> sv/rsst_pkg.sv
`default_nettype none
package rsst_pkg;
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 40;
    localparam int OP_W           = 2;
    localparam int IDX_W          = 11;
    localparam int VAL_IN_W       = 40;
    localparam int SUM_W          = 50;
    localparam int CFG_RESET      = 1024;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_ROOT = 2'd1;
    localparam logic [OP_W-1:0] OP_SUM  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
endpackage
`default_nettype wire

>>> sv/rsst_mem.sv
`default_nettype none
module rsst_mem #(
    parameter int AW = 11,
    parameter int DW = 90
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/rsst_sqrt.sv
`default_nettype none
// Digit-by-digit floor square root, one result bit per cycle.
module rsst_sqrt #(
    parameter int VB = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VB-1:0] i_x,
    output logic               o_done,
    output logic      [VB-1:0] o_root
);
    localparam int RW   = VB + (VB % 2);
    localparam int N    = RW / 2;
    localparam int CNTW = $clog2(N + 1);

    logic [RW-1:0]   r_x;
    logic [N+2:0]    r_rem;
    logic [N-1:0]    r_res;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [N+2:0]    rem_sh;
    logic [N+2:0]    trial;
    logic            take;

    assign rem_sh = {r_rem[N:0], r_x[RW-1 -: 2]};
    assign trial  = (N+3)'({r_res, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNTW'(N - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_x   <= RW'(i_x);
            r_rem <= '0;
            r_res <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[RW-3:0], 2'b00};
            r_rem <= take ? rem_sh - trial : rem_sh;
            r_res <= {r_res[N-2:0], take};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = VB'(r_res);
endmodule
`default_nettype wire

>>> sv/range_sqrt_sum_segment_tree_unit.sv
`default_nettype none
// channel | signals                                                            | dir
// in      | i_in_valid o_in_ready i_opcode i_range_low i_range_high i_new_value | in
// out     | o_out_valid i_out_ready o_range_sum o_bad_range                    | out
// cfg     | i_cfg_we i_cfg_data                                                | in
// Perfect tree over 2**clog2(LEAVES) leaves, one node per memory word, one
// read and one write port. Load writes the leaf and then each parent up to
// the root. Sum walks the tree bottom-up. Root walks it depth-first, pulling
// sums back up, and each leaf is rooted by the shared root unit.
// After reset a clearing pass zeroes all 2*2**D words of the tree; no item is
// taken meanwhile. One item at a time; a finished item waits in the output
// register while the next is taken, and the engine stalls only if a second
// result is ready before the first is taken.
module range_sqrt_sum_segment_tree_unit #(
    parameter int LEAVES     = rsst_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = rsst_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [rsst_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [rsst_pkg::IDX_W-1:0]    i_range_low,
    input  wire logic [rsst_pkg::IDX_W-1:0]    i_range_high,
    input  wire logic [rsst_pkg::VAL_IN_W-1:0] i_new_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [rsst_pkg::SUM_W-1:0]    o_range_sum,
    output logic                               o_bad_range,
    input  wire logic                          i_cfg_we,
    input  wire logic [rsst_pkg::IDX_W-1:0]    i_cfg_data
);
    localparam int D   = $clog2(LEAVES);
    localparam int P   = 2 ** D;
    localparam int AW  = D + 1;
    localparam int VB  = VALUE_BITS;
    localparam int SW  = rsst_pkg::SUM_W;
    localparam int DW  = SW + VB;
    localparam int IW  = rsst_pkg::IDX_W;
    localparam int CW  = ((D + 1 > rsst_pkg::IDX_W) ? D + 1 : rsst_pkg::IDX_W) + 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FIN  = 4'd2;
    localparam logic [3:0] S_LLF  = 4'd3;
    localparam logic [3:0] S_LRD  = 4'd4;
    localparam logic [3:0] S_LWR  = 4'd5;
    localparam logic [3:0] S_QL   = 4'd6;
    localparam logic [3:0] S_QR   = 4'd7;
    localparam logic [3:0] S_QUP  = 4'd8;
    localparam logic [3:0] S_VRD  = 4'd9;
    localparam logic [3:0] S_VCHK = 4'd10;
    localparam logic [3:0] S_VSQ  = 4'd11;
    localparam logic [3:0] S_ADV  = 4'd12;
    localparam logic [3:0] S_PA   = 4'd13;
    localparam logic [3:0] S_PB   = 4'd14;
    localparam logic [3:0] S_PC   = 4'd15;

    logic [3:0]                   r_st, n_st;
    logic [rsst_pkg::IDX_W-1:0]   r_cfg;
    logic [AW-1:0]                r_clr, n_clr;
    logic [AW-1:0]                r_n, n_n;
    logic [AW:0]                  r_ql, n_ql, r_qr, n_qr;
    logic [D:0]                   r_nl, n_nl, r_sz, n_sz;
    logic [CW-1:0]                r_lo0, n_lo0, r_hi0, n_hi0;
    logic [SW-1:0]                r_acc, n_acc, r_as, n_as;
    logic [VB-1:0]                r_am, n_am;
    logic                         r_pend, n_pend;
    logic                         r_bad, n_bad;
    logic [VB-1:0]                r_val, n_val;
    logic                         r_ovalid, n_ovalid;
    logic [SW-1:0]                r_osum, n_osum;
    logic                         r_obad, n_obad;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;
    logic [SW-1:0] rd_sum;
    logic [VB-1:0] rd_max;

    logic          sq_start, sq_done;
    logic [VB-1:0] sq_root;

    logic          accept;
    logic [CW-1:0] cnt, lo_x, hi_x, mn, mx, nl_x, sz_x;
    logic [VB-1:0] in_val;
    logic [VB-1:0] pmax;

    rsst_mem #(.AW(AW), .DW(DW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    rsst_sqrt #(.VB(VB)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_x    (rd_sum[VB-1:0]),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    assign rd_sum = mem_rdata[DW-1 -: SW];
    assign rd_max = mem_rdata[VB-1:0];

    assign o_in_ready  = (r_st == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_range_sum = r_osum;
    assign o_bad_range = r_obad;

    assign cnt    = (CW'(r_cfg) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(r_cfg);
    assign lo_x   = CW'(i_range_low);
    assign hi_x   = CW'(i_range_high);
    assign mn     = (lo_x > hi_x) ? hi_x : lo_x;
    assign mx     = (lo_x > hi_x) ? lo_x : hi_x;
    assign nl_x   = CW'(r_nl);
    assign sz_x   = CW'(r_sz);
    assign in_val = VB'(i_new_value);
    assign pmax   = (r_am > rd_max) ? r_am : rd_max;

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_n = r_n; n_ql = r_ql; n_qr = r_qr;
        n_nl = r_nl; n_sz = r_sz; n_lo0 = r_lo0; n_hi0 = r_hi0;
        n_acc = r_acc; n_as = r_as; n_am = r_am; n_pend = r_pend;
        n_bad = r_bad; n_val = r_val;
        n_ovalid = r_ovalid && !i_out_ready;
        n_osum = r_osum; n_obad = r_obad;
        mem_we = 1'b0; mem_waddr = r_n; mem_wdata = '0; mem_raddr = r_n;
        sq_start = 1'b0;
        unique case (r_st)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_acc = '0;
                    n_bad = 1'b0;
                    n_pend = 1'b0;
                    n_st = S_FIN;
                    unique case (i_opcode)
                        rsst_pkg::OP_LOAD: begin
                            if (lo_x == '0 || lo_x > cnt) begin
                                n_bad = 1'b1;
                            end else begin
                                n_lo0 = lo_x - 1'b1;
                                n_n   = {1'b1, n_lo0[D-1:0]};
                                n_val = in_val;
                                n_st  = S_LLF;
                            end
                        end
                        rsst_pkg::OP_ROOT, rsst_pkg::OP_SUM: begin
                            if (mn == '0 || mx > cnt) begin
                                n_bad = 1'b1;
                            end else begin
                                n_lo0 = mn - 1'b1;
                                n_hi0 = mx - 1'b1;
                                if (i_opcode == rsst_pkg::OP_SUM) begin
                                    n_ql = {2'b01, n_lo0[D-1:0]};
                                    n_qr = (AW+1)'(P) + (AW+1)'(n_hi0) + 1'b1;
                                    n_st = S_QL;
                                end else begin
                                    n_n  = AW'(1);
                                    n_nl = '0;
                                    n_sz = (D+1)'(P);
                                    n_st = S_VRD;
                                end
                            end
                        end
                        rsst_pkg::OP_NONE: n_st = S_FIN;
                        default: n_st = S_FIN;
                    endcase
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_osum   = r_bad ? '0 : r_acc;
                    n_obad   = r_bad;
                    n_st     = S_IDLE;
                end
            end
            S_LLF: begin
                mem_we    = 1'b1;
                mem_wdata = {SW'(r_val), r_val};
                n_as      = SW'(r_val);
                n_am      = r_val;
                n_st      = S_LRD;
            end
            S_LRD: begin
                mem_raddr = r_n ^ AW'(1);
                n_st = (r_n == AW'(1)) ? S_FIN : S_LWR;
            end
            S_LWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_n >> 1;
                n_as      = r_as + rd_sum;
                n_am      = pmax;
                mem_wdata = {n_as, n_am};
                n_n       = r_n >> 1;
                n_st      = S_LRD;
            end
            // Bottom-up half-open query over node indices.
            S_QL: begin
                if (r_ql >= r_qr) begin
                    n_st = S_FIN;
                end else begin
                    n_pend    = r_ql[0];
                    mem_raddr = r_ql[AW-1:0];
                    if (r_ql[0]) n_ql = r_ql + 1'b1;
                    n_st = S_QR;
                end
            end
            S_QR: begin
                if (r_pend) n_acc = r_acc + rd_sum;
                n_pend = r_qr[0];
                n_qr   = r_qr[0] ? r_qr - 1'b1 : r_qr;
                mem_raddr = n_qr[AW-1:0];
                n_st   = S_QUP;
            end
            S_QUP: begin
                if (r_pend) n_acc = r_acc + rd_sum;
                n_ql = r_ql >> 1;
                n_qr = r_qr >> 1;
                n_st = S_QL;
            end
            // Depth-first walk; subtrees with max <= 1 or outside range skipped.
            S_VRD: begin
                mem_raddr = r_n;
                n_st = S_VCHK;
            end
            S_VCHK: begin
                if (rd_max <= VB'(1) || nl_x > r_hi0 || nl_x + sz_x <= r_lo0) begin
                    n_st = S_ADV;
                end else if (r_sz == (D+1)'(1)) begin
                    sq_start = 1'b1;
                    n_st = S_VSQ;
                end else begin
                    n_n  = {r_n[AW-2:0], 1'b0};
                    n_sz = r_sz >> 1;
                    n_st = S_VRD;
                end
            end
            S_VSQ: begin
                if (sq_done) begin
                    mem_we    = 1'b1;
                    mem_wdata = {SW'(sq_root), sq_root};
                    n_st      = S_ADV;
                end
            end
            S_ADV: begin
                if (r_n == AW'(1)) begin
                    n_st = S_FIN;
                end else if (!r_n[0]) begin
                    n_n  = r_n + 1'b1;
                    n_nl = r_nl + r_sz;
                    n_st = S_VRD;
                end else begin
                    n_n  = r_n >> 1;
                    n_nl = r_nl - r_sz;
                    n_sz = r_sz << 1;
                    n_st = S_PA;
                end
            end
            S_PA: begin
                mem_raddr = {r_n[AW-2:0], 1'b0};
                n_st = S_PB;
            end
            S_PB: begin
                mem_raddr = {r_n[AW-2:0], 1'b1};
                n_as = rd_sum;
                n_am = rd_max;
                n_st = S_PC;
            end
            S_PC: begin
                mem_we    = 1'b1;
                mem_wdata = {r_as + rd_sum, pmax};
                n_st      = S_ADV;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            r_cfg    <= IW'(rsst_pkg::CFG_RESET);
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_cfg <= i_cfg_data;
        end
        r_n <= n_n; r_ql <= n_ql; r_qr <= n_qr; r_nl <= n_nl; r_sz <= n_sz;
        r_lo0 <= n_lo0; r_hi0 <= n_hi0; r_acc <= n_acc; r_as <= n_as;
        r_am <= n_am; r_pend <= n_pend; r_bad <= n_bad; r_val <= n_val;
        r_osum <= n_osum; r_obad <= n_obad;
    end

`ifndef SYNTHESIS
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CLR) |-> !o_out_valid) else $error("result during clear");
    a_bad_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_range) |-> (o_range_sum == '0)) else $error("bad with sum");
    a_none_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == rsst_pkg::OP_NONE) |=> (r_st == S_FIN))
        else $error("unused opcode not finished");
`endif
endmodule
`default_nettype wire

>>> tb/sv/tb_range_sqrt_sum_segment_tree_unit.sv
`timescale 1ns / 100ps
module tb_range_sqrt_sum_segment_tree_unit;
    localparam int NLEAF    = 1024;
    localparam int WD_LIMIT = 200000;
    localparam int OP_W     = rsst_pkg::OP_W;
    localparam int IDX_W    = rsst_pkg::IDX_W;
    localparam int VAL_IN_W = rsst_pkg::VAL_IN_W;
    localparam int SUM_W    = rsst_pkg::SUM_W;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    lo;
        logic [IDX_W-1:0]    hi;
        logic [VAL_IN_W-1:0] val;
    } t_seg_req;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             bad;
    } t_seg_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_opcode = '0;
    logic [IDX_W-1:0]    i_range_low = '0;
    logic [IDX_W-1:0]    i_range_high = '0;
    logic [VAL_IN_W-1:0] i_new_value = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [SUM_W-1:0]    o_range_sum;
    logic                o_bad_range;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_data = '0;

    range_sqrt_sum_segment_tree_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .i_new_value (i_new_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_range_sum (o_range_sum),
        .o_bad_range (o_bad_range),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_seg_req            pending_reqs[$];
    t_seg_res            expected_sums[$];
    logic [VAL_IN_W-1:0] leaf_val[1:NLEAF];
    int                  leaf_count = NLEAF;
    int                  mismatches = 0;
    int                  items_sent = 0;
    int                  results_seen = 0;
    int                  op_seen[4] = '{0, 0, 0, 0};
    int                  bad_seen = 0;
    int                  idle_cycles = 0;

    function automatic logic [19:0] floor_sqrt(input logic [VAL_IN_W-1:0] x);
        logic [19:0] r;
        logic [19:0] t;
        r = '0;
        for (int b = 19; b >= 0; b--) begin
            t = r | (20'd1 << b);
            if (64'(t) * 64'(t) <= 64'(x))
                r = t;
        end
        return r;
    endfunction

    // updates the leaf store and returns the result the block must give
    function automatic t_seg_res seg_apply(input t_seg_req q);
        t_seg_res   res;
        int         lo;
        int         hi;
        int         tmp;
        logic [63:0] acc;
        res.sum = '0;
        res.bad = 1'b0;
        lo = q.lo;
        hi = q.hi;
        acc = '0;
        unique case (q.op)
            rsst_pkg::OP_LOAD: begin
                if (lo < 1 || lo > leaf_count)
                    res.bad = 1'b1;
                else
                    leaf_val[lo] = q.val;
            end
            rsst_pkg::OP_ROOT, rsst_pkg::OP_SUM: begin
                if (lo > hi) begin
                    tmp = lo; lo = hi; hi = tmp;
                end
                if (lo < 1 || hi > leaf_count)
                    res.bad = 1'b1;
                else if (q.op == rsst_pkg::OP_ROOT) begin
                    for (int i = lo; i <= hi; i++)
                        leaf_val[i] = VAL_IN_W'(floor_sqrt(leaf_val[i]));
                end else begin
                    for (int i = lo; i <= hi; i++)
                        acc += 64'(leaf_val[i]);
                    res.sum = acc[SUM_W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_seg_req nx;
        if (i_in_valid && o_in_ready) begin
            expected_sums.insert(expected_sums.size(), seg_apply(
                '{op: i_opcode, lo: i_range_low, hi: i_range_high, val: i_new_value}));
            op_seen[i_opcode]++;
            items_sent++;
        end
        if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nx = pending_reqs.pop_front();
                i_in_valid   <= 1'b1;
                i_opcode     <= nx.op;
                i_range_low  <= nx.lo;
                i_range_high <= nx.hi;
                i_new_value  <= nx.val;
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
                end
            end else
                i_in_valid <= 1'b0;
        end
    end

    // ---------------- receiver and checker ----------------
    int  stall_left = 0;
    bit  long_hold_done = 0;
    logic [3:0] rdy_pat = 4'b1011;

    always @(posedge i_clk) begin
        t_seg_res want;
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sum=%0d bad=%0b", o_range_sum, o_bad_range);
            end else begin
                want = expected_sums.pop_front();
                if (want.bad)
                    bad_seen++;
                if (want.sum !== o_range_sum || want.bad !== o_bad_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected sum=%0d bad=%0b, got sum=%0d bad=%0b",
                                 results_seen, want.sum, want.bad, o_range_sum, o_bad_range);
                end
            end
        end
        if (!long_hold_done && items_sent >= 300) begin
            long_hold_done = 1;
            stall_left = 500;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 15) == 0)
                rdy_pat = 4'($urandom);
            rdy_pat = {rdy_pat[2:0], rdy_pat[3]};
            i_out_ready <= rdy_pat[0] | (rdy_pat == 4'b0000);
            if ($urandom_range(0, 60) == 0)
                stall_left = $urandom_range(5, 40);
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (pending_reqs.size() == 0 && !i_in_valid && expected_sums.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [VAL_IN_W-1:0] rand_value();
        int mag;
        mag = $urandom_range(0, VAL_IN_W);
        return VAL_IN_W'({$urandom, $urandom} & ((64'd1 << mag) - 64'd1));
    endfunction

    function automatic t_seg_req rand_req();
        t_seg_req q;
        int c;
        int r;
        int span;
        logic [IDX_W-1:0] t;
        c = leaf_count < 1 ? 1 : leaf_count;
        r = $urandom_range(0, 99);
        q.val = rand_value();
        if (r < 90) begin
            q.op = r < 35 ? rsst_pkg::OP_LOAD : (r < 55 ? rsst_pkg::OP_ROOT : rsst_pkg::OP_SUM);
            q.lo = IDX_W'($urandom_range(1, c));
            span = $urandom_range(0, 4) == 0 ? $urandom_range(0, c) : $urandom_range(0, 16);
            q.hi = IDX_W'((q.lo + span > c) ? c : q.lo + span);
            if ($urandom_range(0, 2) == 0) begin
                t = q.lo; q.lo = q.hi; q.hi = t;
            end
        end else begin
            // noise: any opcode, indices anywhere in the field
            q.op = OP_W'($urandom);
            q.lo = IDX_W'($urandom);
            q.hi = IDX_W'($urandom);
            if ($urandom_range(0, 1) == 0)
                q.lo = IDX_W'($urandom_range(0, c + 1));
        end
        return q;
    endfunction

    task automatic push_req(input logic [OP_W-1:0] op, input int lo, input int hi,
                            input logic [VAL_IN_W-1:0] val);
        pending_reqs.insert(pending_reqs.size(),
                            '{op: op, lo: IDX_W'(lo), hi: IDX_W'(hi), val: val});
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_sums.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_count(input int v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= IDX_W'(v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        leaf_count = v > NLEAF ? NLEAF : v;
    endtask

    task automatic random_phase(input int cnt, input int n);
        set_count(cnt);
        repeat (n) pending_reqs.insert(pending_reqs.size(), rand_req());
        wait_drained();
    endtask

    localparam logic [VAL_IN_W-1:0] VMAX = '1;

    initial begin
        for (int i = 1; i <= NLEAF; i++)
            leaf_val[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int w = 0; w < WD_LIMIT && !o_in_ready; w++)
            @(posedge i_clk);
        if (!o_in_ready) begin
            $display("TEST FAILED");
            $finish;
        end

        // directed: extremes, every op, reversed bounds, bad indices, opcode 3
        set_count(rsst_pkg::CFG_RESET);
        push_req(rsst_pkg::OP_SUM, 1, 1024, '0);
        push_req(rsst_pkg::OP_LOAD, 1, 0, VMAX);
        push_req(rsst_pkg::OP_LOAD, 1024, 0, VMAX);
        push_req(rsst_pkg::OP_LOAD, 512, 0, 40'd1);
        push_req(rsst_pkg::OP_LOAD, 513, 0, 40'd99);
        push_req(rsst_pkg::OP_SUM, 1024, 1, '0);
        push_req(rsst_pkg::OP_ROOT, 1, 1024, '0);
        push_req(rsst_pkg::OP_SUM, 1, 1024, '0);
        push_req(rsst_pkg::OP_ROOT, 600, 2, '0);
        push_req(rsst_pkg::OP_SUM, 1, 1, '0);
        push_req(rsst_pkg::OP_SUM, 513, 513, '0);
        push_req(rsst_pkg::OP_LOAD, 0, 5, VMAX);
        push_req(rsst_pkg::OP_LOAD, 1025, 5, VMAX);
        push_req(rsst_pkg::OP_ROOT, 0, 10, '0);
        push_req(rsst_pkg::OP_SUM, 5, 2047, '0);
        push_req(rsst_pkg::OP_SUM, 2047, 0, '0);
        push_req(rsst_pkg::OP_NONE, 2047, 2047, VMAX);
        push_req(rsst_pkg::OP_NONE, 0, 0, '0);
        for (int i = 1; i <= 4; i++)
            push_req(rsst_pkg::OP_LOAD, 700 + i, 0, VMAX >> (i * 9));
        push_req(rsst_pkg::OP_ROOT, 701, 704, '0);
        push_req(rsst_pkg::OP_ROOT, 704, 701, '0);
        push_req(rsst_pkg::OP_SUM, 700, 705, '0);
        wait_drained();

        random_phase(1, 40);
        random_phase(2047, 200);
        random_phase(0, 20);
        random_phase(37, 120);
        random_phase(rsst_pkg::CFG_RESET, 200);
        random_phase(512, 150);

        $display("items: %0d (load %0d, root %0d, sum %0d, unused %0d), results: %0d",
                 items_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], results_seen);
        $display("out-of-range items: %0d, leaf counts 1, 37, 512, 1024, 2047 and 0",
                 bad_seen);
        if (mismatches == 0 && expected_sums.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
